/* sv/mtp_pkg.sv */
`timescale 1ns / 1ps
// Types and constants shared by the format-0 MIDI track parser.
// No dependencies.
package mtp_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_HMAGIC, PH_HLEN, PH_HFMT, PH_HTRKS, PH_HDIV, PH_HSKIP,
        PH_TMAGIC, PH_TLEN, PH_DELTA, PH_STATUS, PH_NOTE, PH_VEL, PH_MTYPE,
        PH_MLEN, PH_MDATA, PH_SKIP2, PH_FINPEND
    } phase_t;

    typedef enum logic [1:0] {
        T_IDLE, T_MUL, T_DIV, T_DONE
    } tstate_t;

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [1:0] ERR_FILE_HDR  = 2'd0;
    localparam logic [1:0] ERR_FORMAT    = 2'd1;
    localparam logic [1:0] ERR_TRACK_HDR = 2'd2;

    localparam logic [31:0] HDR_MAGIC = 32'h4D546864; // "MThd"
    localparam logic [31:0] TRK_MAGIC = 32'h4D54726B; // "MTrk"
    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [7:0]  META_STATUS = 8'hFF;
    localparam logic [7:0]  META_TEMPO  = 8'h51;
    localparam logic [3:0]  NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0]  NIB_NOTE_OFF = 4'h8;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int          PROD_W = 56;

    typedef struct packed {
        logic       valid;
        logic       timed;
        logic [1:0] kind;
        logic [1:0] err;
        logic [7:0] note;
        logic [7:0] vel;
    } result_t;

    typedef struct packed {
        logic load_plain;
        logic capture;
        logic mul;
        logic div_step;
        logic load_timed;
    } dp_cmd_t;

    function automatic logic [7:0] magic_byte(input logic trk, input logic [1:0] idx);
        logic [31:0] m;
        m = trk ? TRK_MAGIC : HDR_MAGIC;
        magic_byte = m[8 * (3 - idx) +: 8];
    endfunction

endpackage

/* sv/mtp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for parser input bytes and result items.
// Depends on nothing.
interface mtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;
    modport source (output valid, data_byte, file_start, input ready);
    modport sink (input valid, data_byte, file_start, output ready);
endinterface

interface mtp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [1:0]  error_code;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [47:0] time_us;
    modport source (output valid, event_kind, error_code, note_number, velocity, time_us,
                    input ready);
    modport sink (input valid, event_kind, error_code, note_number, velocity, time_us,
                  output ready);
endinterface

/* sv/midi_track_event_parser_core.sv */
`timescale 1ns / 1ps
// Format-0 MIDI file parser, top level: parser, controller and datapath.
// Depends on mtp_pkg, mtp_if, mtp_parser, mtp_ctrl, mtp_dp.
//
// Usage: item_in carries one file byte per item; file_start marks the first
// byte of a file and restarts all parse state. item_out carries note on/off,
// track finished and parse error items.
// Timing: errors and track-finished items appear in the cycle after the
// byte is accepted. A note item passes through a multiply step, the divide
// steps (one quotient bit per cycle in the restoring divider) and a load
// step, which waits while the result register is full.
// Throughput: one byte per cycle while the result register can take an item;
// after a velocity byte, input is held off while the note item is computed.
// Stall: the single result register holds its item until item_out.ready;
// no byte is taken while that register is full and not being drained.
// Reset: rst_n clears the parser to waiting for a file start, tempo
// 500000 us per quarter, and empties the result register.
module midi_track_event_parser_core
    import mtp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    mtp_in_if.sink    item_in,
    mtp_out_if.source item_out
);

    result_t     res;
    dp_cmd_t     cmd;
    logic [31:0] ticks;
    logic [23:0] tempo;
    logic [15:0] tpq;
    logic        acc;

    assign acc = item_in.valid && item_in.ready;

    mtp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .b     (item_in.data_byte),
        .fs    (item_in.file_start),
        .res   (res),
        .ticks (ticks),
        .tempo (tempo),
        .tpq   (tpq)
    );

    mtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (item_out.valid),
        .out_ready (item_out.ready),
        .res       (res),
        .cmd       (cmd)
    );

    mtp_dp u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .res     (res),
        .ticks   (ticks),
        .tempo   (tempo),
        .tpq     (tpq),
        .kind    (item_out.event_kind),
        .err     (item_out.error_code),
        .note    (item_out.note_number),
        .vel     (item_out.velocity),
        .time_us (item_out.time_us)
    );

endmodule

/* sv/mtp_parser.sv */
`timescale 1ns / 1ps
// Byte-level parse state machine: header, track header and event walking.
// Depends on mtp_pkg.
module mtp_parser
    import mtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        acc,
    input  logic [7:0]  b,
    input  logic        fs,
    output result_t     res,
    output logic [31:0] ticks,
    output logic [23:0] tempo,
    output logic [15:0] tpq
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  fbc_reg, fbc_next;
    logic [31:0] hsl_reg, hsl_next;
    logic [15:0] tpq_reg, tpq_next;
    logic [31:0] tbl_reg, tbl_next;
    logic [27:0] qa_reg, qa_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [7:0]  stat_reg, stat_next;
    logic [7:0]  note_reg, note_next;
    logic [7:0]  mt_reg, mt_next;
    logic [27:0] mbl_reg, mbl_next;
    logic [23:0] ta_reg, ta_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fbc_reg   <= '0;
            hsl_reg   <= '0;
            tpq_reg   <= '0;
            tbl_reg   <= '0;
            qa_reg    <= '0;
            ticks_reg <= '0;
            tempo_reg <= TEMPO_DEFAULT;
            stat_reg  <= '0;
            note_reg  <= '0;
            mt_reg    <= '0;
            mbl_reg   <= '0;
            ta_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            hsl_reg   <= hsl_next;
            tpq_reg   <= tpq_next;
            tbl_reg   <= tbl_next;
            qa_reg    <= qa_next;
            ticks_reg <= ticks_next;
            tempo_reg <= tempo_next;
            stat_reg  <= stat_next;
            note_reg  <= note_next;
            mt_reg    <= mt_next;
            mbl_reg   <= mbl_next;
            ta_reg    <= ta_next;
        end
    end

    assign ticks = ticks_reg;
    assign tempo = tempo_reg;
    assign tpq   = tpq_reg;

    always_comb
    begin
        logic is_on;
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        hsl_next   = hsl_reg;
        tpq_next   = tpq_reg;
        tbl_next   = tbl_reg;
        qa_next    = qa_reg;
        ticks_next = ticks_reg;
        tempo_next = tempo_reg;
        stat_next  = stat_reg;
        note_next  = note_reg;
        mt_next    = mt_reg;
        mbl_next   = mbl_reg;
        ta_next    = ta_reg;
        res        = '0;
        is_on      = (stat_reg[7:4] == NIB_NOTE_ON);
        if (acc)
        begin
            if (fs)
            begin
                phase_next = PH_HMAGIC;
                fbc_next   = '0;
                hsl_next   = '0;
                tpq_next   = '0;
                tbl_next   = '0;
                qa_next    = '0;
                ticks_next = '0;
                tempo_next = TEMPO_DEFAULT;
                stat_next  = '0;
                note_next  = '0;
                mt_next    = '0;
                mbl_next   = '0;
                ta_next    = '0;
            end
            // track byte count runs down inside the event phases
            if (phase_next >= PH_DELTA && phase_next <= PH_SKIP2 && tbl_next != '0)
                tbl_next = tbl_next - 32'd1;

            unique case (phase_next)
                PH_HMAGIC, PH_TMAGIC:
                begin
                    if (b != magic_byte(phase_next == PH_TMAGIC, fbc_next[1:0]))
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_ERROR;
                        res.err   = (phase_next == PH_HMAGIC) ? ERR_FILE_HDR : ERR_TRACK_HDR;
                        phase_next = PH_IDLE;
                    end
                    else if (fbc_next == 3'd3)
                    begin
                        fbc_next   = '0;
                        phase_next = (phase_next == PH_HMAGIC) ? PH_HLEN : PH_TLEN;
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_HLEN:
                begin
                    hsl_next = {hsl_next[23:0], b};
                    if (fbc_next == 3'd3)
                    begin
                        fbc_next   = '0;
                        hsl_next   = (hsl_next >= 32'd6) ? hsl_next - 32'd6 : '0;
                        qa_next    = '0;
                        phase_next = PH_HFMT;
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_HFMT:
                begin
                    qa_next = {12'd0, qa_next[7:0], b};
                    if (fbc_next == 3'd1)
                    begin
                        fbc_next = '0;
                        if (qa_next != '0)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.err    = ERR_FORMAT;
                            phase_next = PH_IDLE;
                        end
                        else
                            phase_next = PH_HTRKS;
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_HTRKS:
                begin
                    if (fbc_next == 3'd1)
                    begin
                        fbc_next   = '0;
                        phase_next = PH_HDIV;
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_HDIV:
                begin
                    tpq_next = {tpq_next[7:0], b};
                    if (fbc_next == 3'd1)
                    begin
                        fbc_next   = '0;
                        phase_next = (hsl_next == '0) ? PH_TMAGIC : PH_HSKIP;
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_HSKIP:
                begin
                    if (hsl_next != '0)
                        hsl_next = hsl_next - 32'd1;
                    if (hsl_next == '0)
                        phase_next = PH_TMAGIC;
                end
                PH_TLEN:
                begin
                    tbl_next = {tbl_next[23:0], b};
                    if (fbc_next == 3'd3)
                    begin
                        fbc_next = '0;
                        qa_next  = '0;
                        if (tbl_next == '0)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_FINISHED;
                            phase_next = PH_IDLE;
                        end
                        else
                            phase_next = PH_DELTA;
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_DELTA:
                begin
                    qa_next = {qa_next[20:0], b[6:0]};
                    if (!b[7])
                    begin
                        ticks_next = ticks_next + {4'd0, qa_next};
                        qa_next    = '0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    stat_next = b;
                    if (b[7:4] == NIB_NOTE_ON || b[7:4] == NIB_NOTE_OFF)
                        phase_next = PH_NOTE;
                    else if (b == META_STATUS)
                        phase_next = PH_MTYPE;
                    else
                    begin
                        fbc_next   = '0;
                        phase_next = PH_SKIP2;
                    end
                end
                PH_NOTE:
                begin
                    note_next  = b;
                    phase_next = PH_VEL;
                end
                PH_VEL:
                begin
                    res.valid = 1'b1;
                    res.timed = 1'b1;
                    res.note  = note_next;
                    if (is_on && b != '0)
                    begin
                        res.kind = KIND_NOTE_ON;
                        res.vel  = b;
                    end
                    else
                    begin
                        res.kind = KIND_NOTE_OFF;
                        res.vel  = is_on ? 8'd0 : b;
                    end
                    qa_next    = '0;
                    phase_next = (tbl_next == '0) ? PH_FINPEND : PH_DELTA;
                end
                PH_MTYPE:
                begin
                    mt_next    = b;
                    qa_next    = '0;
                    phase_next = PH_MLEN;
                end
                PH_MLEN:
                begin
                    qa_next = {qa_next[20:0], b[6:0]};
                    if (!b[7])
                    begin
                        mbl_next = qa_next;
                        qa_next  = '0;
                        if (!(mt_next == META_TEMPO && mbl_next == 28'd3))
                            mt_next = '0;
                        ta_next = '0;
                        if (mbl_next == '0)
                        begin
                            phase_next = PH_DELTA;
                            if (tbl_next == '0)
                            begin
                                res.valid  = 1'b1;
                                res.kind   = KIND_FINISHED;
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                            phase_next = PH_MDATA;
                    end
                end
                PH_MDATA:
                begin
                    if (mt_next == META_TEMPO)
                        ta_next = {ta_next[15:0], b};
                    if (mbl_next != '0)
                        mbl_next = mbl_next - 28'd1;
                    if (mbl_next == '0)
                    begin
                        if (mt_next == META_TEMPO)
                            tempo_next = ta_next;
                        qa_next    = '0;
                        phase_next = PH_DELTA;
                        if (tbl_next == '0)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_FINISHED;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_SKIP2:
                begin
                    if (fbc_next == 3'd1)
                    begin
                        fbc_next   = '0;
                        qa_next    = '0;
                        phase_next = PH_DELTA;
                        if (tbl_next == '0)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_FINISHED;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                        fbc_next = fbc_next + 3'd1;
                end
                PH_FINPEND:
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_FINISHED;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/mtp_ctrl.sv */
`timescale 1ns / 1ps
// Controller: input handshake, result slot and multiply/divide sequencing.
// Depends on mtp_pkg.
module mtp_ctrl
    import mtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  result_t res,
    output dp_cmd_t cmd
);

    tstate_t    state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == T_IDLE) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_valid && in_ready && res.valid)
                begin
                    if (res.timed)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = T_MUL;
                    end
                    else
                    begin
                        cmd.load_plain = 1'b1;
                        ov_next        = 1'b1;
                    end
                end
            end
            T_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = T_DIV;
            end
            T_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(PROD_W - 1))
                    state_next = T_DONE;
            end
            T_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_timed = 1'b1;
                    ov_next        = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

endmodule

/* sv/mtp_dp.sv */
`timescale 1ns / 1ps
// Datapath: tick*tempo product, bit-serial divide by ticks per quarter,
// saturation and the result register. Depends on mtp_pkg.
module mtp_dp
    import mtp_pkg::*;
(
    input  logic        clk,
    input  dp_cmd_t     cmd,
    input  result_t     res,
    input  logic [31:0] ticks,
    input  logic [23:0] tempo,
    input  logic [15:0] tpq,
    output logic [1:0]  kind,
    output logic [1:0]  err,
    output logic [7:0]  note,
    output logic [7:0]  vel,
    output logic [47:0] time_us
);

    logic [31:0]       ticks_reg;
    logic [23:0]       tempo_reg;
    logic [15:0]       div_reg;
    logic [1:0]        ckind_reg;
    logic [7:0]        cnote_reg, cvel_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [15:0]       rem_reg;
    logic [1:0]        kind_reg, err_reg;
    logic [7:0]        note_reg, vel_reg;
    logic [47:0]       time_reg;
    logic [16:0]       trial;
    logic [47:0]       time_sat;

    // one restoring-divide step: shift in next dividend bit, subtract if it fits
    assign trial    = {rem_reg, quo_reg[PROD_W-1]};
    assign time_sat = (div_reg == '0 || quo_reg[PROD_W-1:48] != '0) ? TIME_MAX
                      : quo_reg[47:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ticks_reg <= ticks;
            tempo_reg <= tempo;
            div_reg   <= tpq;
            ckind_reg <= res.kind;
            cnote_reg <= res.note;
            cvel_reg  <= res.vel;
        end
        if (cmd.mul)
        begin
            // full 56-bit product of the 32-bit ticks and 24-bit tempo
            quo_reg <= {24'd0, ticks_reg} * {32'd0, tempo_reg};
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= 16'(trial - {1'b0, div_reg});
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
        if (cmd.load_plain)
        begin
            kind_reg <= res.kind;
            err_reg  <= res.err;
            note_reg <= '0;
            vel_reg  <= '0;
            time_reg <= '0;
        end
        if (cmd.load_timed)
        begin
            kind_reg <= ckind_reg;
            err_reg  <= ERR_FILE_HDR;
            note_reg <= cnote_reg;
            vel_reg  <= cvel_reg;
            time_reg <= time_sat;
        end
    end

    assign kind    = kind_reg;
    assign err     = err_reg;
    assign note    = note_reg;
    assign vel     = vel_reg;
    assign time_us = time_reg;

endmodule
